// ----- sv/pctd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pctd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;  // log2(QDEPTH)
  localparam int QLW    = 3;  // holds 0..QDEPTH

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  // up to three decoded bytes from one input byte, bytes[0] goes out first
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QLW-1:0] level;
  } qstat_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // digits give their low nibble, letters add nine
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [3:0] v;
    v = b[3:0];
    if (b[6]) v = v + 4'd9;
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- sv/percent_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  transfer when        payload
// s_*       in   s_tvalid & s_tready  tdata[7:0] in_byte, tlast in_last
// m_*       out  m_tvalid & m_tready  tdata[7:0] out_byte, tlast out_last
// cfg_*     in   cfg_we               cfg_data plus_as_space
//
// One input byte per cycle while the command queue has room; the back end
// sends one decoded byte per cycle while m_tready allows, so a failed escape
// (up to three bytes out) keeps the back end busy while the four-entry command
// queue absorbs the input. Input passes the queue write, then the output register.
// rst is synchronous: it clears held state, queue, output valid and
// plus_as_space. s_tready drops only when the command queue is full.
module percent_decoder_top import pctd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // in_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // out_last
  input  wire logic       cfg_we,
  input  wire logic       cfg_data   // plus_as_space
);

  logic   plus_as_space;
  logic   push;
  logic   pop;
  cmd_t   cmd;
  cmd_t   head;
  qstat_t stat;
  held_t  held;

  // form-mode switch; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) plus_as_space <= 1'b0;
    else if (cfg_we) plus_as_space <= cfg_data;
  end

  // front: escape tracking, turns each accepted byte into a short command, or none while an escape is held
  pctd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_byte  (s_tdata),
    .s_last  (s_tlast),
    .q_full  (stat.full),
    .s_ready (s_tready),
    .push    (push),
    .cmd     (cmd),
    .held    (held)
  );

  pctd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // back: plays each command out a byte at a time into the output register
  pctd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (stat),
    .plus_as_space (plus_as_space),
    .m_tready      (m_tready),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

  // queue must never be pushed past its depth
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    stat.level <= QLW'(QDEPTH))
    else $error("command queue overflow");

  // end of string leaves nothing held
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (held == HELD_NONE))
    else $error("held state survives end of string");

  // form mode never lets a plus through
  a_no_plus: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && plus_as_space && $stable(plus_as_space)) |-> (m_tdata != PLUS_CHAR))
    else $error("plus byte in form mode");

endmodule
`default_nettype wire

// ----- sv/pctd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pctd_front import pctd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  input  wire logic [7:0] s_byte,
  input  wire logic       s_last,
  input  wire logic       q_full,
  output logic            s_ready,
  output logic            push,
  output cmd_t            cmd,
  output held_t           held
);

  held_t      held_next;
  logic [7:0] digit;
  logic [7:0] digit_next;
  logic       acc;
  logic       hex;

  assign s_ready = !q_full;
  assign acc     = s_valid && s_ready;
  assign hex     = is_hex(s_byte);

  // next state
  always_comb begin
    held_next  = held;
    digit_next = digit;
    if (acc) begin
      unique case (held)
        HELD_PCT: begin
          if (hex) begin
            held_next  = HELD_DIGIT;
            digit_next = s_byte;
          end else begin
            held_next = (s_byte == PCT_CHAR) ? HELD_PCT : HELD_NONE;
          end
        end
        HELD_DIGIT: begin
          if (hex) held_next = HELD_NONE;
          else held_next = (s_byte == PCT_CHAR) ? HELD_PCT : HELD_NONE;
        end
        default: begin
          held_next = (s_byte == PCT_CHAR) ? HELD_PCT : HELD_NONE;
        end
      endcase
      if (s_last) begin
        held_next  = HELD_NONE;
        digit_next = '0;
      end
    end
  end

  // outputs: bytes emitted for this input, in order
  always_comb begin
    held_t      mid;
    logic [7:0] mdig;
    logic       plain;
    logic [1:0] n;
    mid       = HELD_NONE;
    mdig      = digit;
    plain     = 1'b0;
    n         = 2'd0;
    cmd.bytes = '0;
    unique case (held)
      HELD_PCT: begin
        if (hex) begin
          mid  = HELD_DIGIT;
          mdig = s_byte;
        end else begin
          cmd.bytes[n] = PCT_CHAR;
          n            = n + 2'd1;
          plain        = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (hex) begin
          cmd.bytes[n] = {hex_nib(digit), hex_nib(s_byte)};
          n            = n + 2'd1;
        end else begin
          cmd.bytes[n] = PCT_CHAR;
          n            = n + 2'd1;
          cmd.bytes[n] = digit;
          n            = n + 2'd1;
          plain        = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (s_byte == PCT_CHAR) begin
        mid = HELD_PCT;
      end else begin
        cmd.bytes[n] = s_byte;
        n            = n + 2'd1;
      end
    end
    // end of string: flush whatever is still held
    if (s_last) begin
      if (mid == HELD_PCT) begin
        cmd.bytes[n] = PCT_CHAR;
        n            = n + 2'd1;
      end else if (mid == HELD_DIGIT) begin
        cmd.bytes[n] = PCT_CHAR;
        n            = n + 2'd1;
        cmd.bytes[n] = mdig;
        n            = n + 2'd1;
      end
    end
    cmd.cnt  = n;
    cmd.last = s_last;
    push     = acc && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= HELD_NONE;
      digit <= '0;
    end else begin
      held  <= held_next;
      digit <= digit_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pctd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pctd_queue import pctd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output qstat_t    stat
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QLW-1:0] level;

  assign head       = entries[rd_ptr];
  assign stat.level = level;
  assign stat.full  = (level == QLW'(QDEPTH));
  assign stat.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pctd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pctd_back import pctd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       head,
  input  wire qstat_t     stat,
  input  wire logic       plus_as_space,
  input  wire logic       m_tready,
  output logic            pop,
  output logic            m_tvalid,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  logic [1:0] idx;
  logic       load;
  logic       fin;
  logic [7:0] sel;

  // output slot refills from a non-empty queue whenever it is empty or being drained
  assign load = !stat.empty && (!m_tvalid || m_tready);
  assign sel  = head.bytes[idx];
  assign fin  = (idx == head.cnt - 2'd1);
  assign pop  = load && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= fin ? 2'd0 : idx + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= (plus_as_space && sel == PLUS_CHAR) ? SPACE_CHAR : sel;
      m_tlast <= head.last && fin;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/percent_decoder_top_tb.sv -----
`timescale 1ns / 1ps
module percent_decoder_top_tb;
  import pctd_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int SETTLE_CYCLES  = 8;    // well past the queue write and output register
  localparam int HOLDOFF_CYCLES = 60;   // long enough to fill the command queue
  localparam int MAX_REPORTS    = 20;

  // one transfer on either side: byte and end-of-string mark
  typedef struct packed {
    logic [7:0] val;
    logic       tl;
  } xfer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;    // in_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // out_last
  logic       cfg_we = 1'b0;
  logic       cfg_data = 1'b0;   // plus_as_space

  xfer_t pending_q[$];   // encoded bytes waiting to be offered
  xfer_t decoded_q[$];   // decoded bytes still owed by the block

  // decoder state as predicted
  held_t      held = HELD_NONE;
  logic [7:0] held_dig = 8'h00;
  logic       form_mode = 1'b0;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   holdoff_req = 1'b0;
  logic hold_rx = 1'b0;

  int err_count = 0;
  int n_in = 0;
  int n_out = 0;
  int n_strings = 0;
  int n_escapes = 0;
  int n_broken = 0;
  int stall_cycles = 0;

  percent_decoder_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop; far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decode prediction
  // ---------------------------------------------------------------------------

  // bit 4 flags a hex digit, [3:0] is its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h41 + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h61 + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // form mode rewrites every '+' leaving the block, escaped ones too
  function automatic void owe_byte(input logic [7:0] b, inout int n);
    xfer_t e;
    e.val = (form_mode && b == PLUS_CHAR) ? SPACE_CHAR : b;
    e.tl  = 1'b0;
    decoded_q.push_back(e);
    n++;
  endfunction

  function automatic void take_plain(input logic [7:0] b, inout int n);
    if (b == PCT_CHAR) begin
      held = HELD_PCT;
    end else begin
      owe_byte(b, n);
      held = HELD_NONE;
    end
  endfunction

  function automatic void decode_transfer(input logic [7:0] b, input logic eos);
    logic [4:0] d;
    logic [4:0] hi;
    int n;
    n = 0;
    d = hex_digit(b);
    case (held)
      HELD_PCT: begin
        if (d[4]) begin
          held_dig = b;
          held = HELD_DIGIT;
        end else begin
          // failed escape: '%' goes out, byte is taken afresh
          n_broken++;
          owe_byte(PCT_CHAR, n);
          take_plain(b, n);
        end
      end
      HELD_DIGIT: begin
        if (d[4]) begin
          hi = hex_digit(held_dig);
          owe_byte({hi[3:0], d[3:0]}, n);
          held = HELD_NONE;
          n_escapes++;
        end else begin
          n_broken++;
          owe_byte(PCT_CHAR, n);
          owe_byte(held_dig, n);
          take_plain(b, n);
        end
      end
      default: take_plain(b, n);
    endcase
    if (eos) begin
      // flush whatever is held as literals
      if (held == HELD_PCT) begin
        owe_byte(PCT_CHAR, n);
      end else if (held == HELD_DIGIT) begin
        owe_byte(PCT_CHAR, n);
        owe_byte(held_dig, n);
      end
      held = HELD_NONE;
      held_dig = 8'h00;
      if (n > 0) decoded_q[decoded_q.size() - 1].tl = 1'b1;
      n_strings++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t ns MISMATCH: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending bytes, predicts on each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    xfer_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_transfer(s_tdata, s_tlast);
        n_in++;
      end
      if (s_tvalid && !s_tready) stall_cycles++;
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.val;
          s_tlast <= it.tl;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each decoded transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    xfer_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          e = decoded_q.pop_front();
          if (m_tdata !== e.val)
            report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, e.val));
          if (m_tlast !== e.tl)
            report_mismatch($sformatf("out_last %0b, want %0b (byte %02h)",
                                      m_tlast, e.tl, e.val));
        end
      end
      m_tready <= hold_rx ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, timed here so the sender keeps going meanwhile
  initial begin
    wait (holdoff_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add(input logic [7:0] b, input logic eos);
    xfer_t it;
    it.val = b;
    it.tl  = eos;
    pending_q.push_back(it);
  endfunction

  function automatic logic [7:0] any_hex();
    case ($urandom_range(2))
      0:       return 8'h30 + 8'($urandom_range(9));
      1:       return 8'h41 + 8'($urandom_range(5));
      default: return 8'h61 + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    logic [4:0] d;
    do begin
      b = 8'($urandom_range(1, 255));
      d = hex_digit(b);
    end while (d[4]);
    return b;
  endfunction

  // mostly printable text, now and then any byte; never '%'
  function automatic logic [7:0] literal();
    logic [7:0] b;
    do begin
      if ($urandom_range(3) == 0) b = 8'($urandom_range(1, 255));
      else b = 8'($urandom_range(8'h20, 8'h7E));
    end while (b == PCT_CHAR);
    return b;
  endfunction

  // one string, possibly with broken escapes; returns its length
  function automatic int add_string();
    int k;
    int start;
    start = pending_q.size();
    k = $urandom_range(1, 8);
    repeat (k) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: add(literal(), 1'b0);
        5, 6: begin
          add(PCT_CHAR, 1'b0);
          add(any_hex(), 1'b0);
          add(any_hex(), 1'b0);
        end
        7: begin
          // escaped plus, exercises form mode on decoded bytes
          add(PCT_CHAR, 1'b0);
          add(8'h32, 1'b0);
          add($urandom_range(1) ? 8'h42 : 8'h62, 1'b0);
        end
        8: add(PLUS_CHAR, 1'b0);
        default: begin
          add(PCT_CHAR, 1'b0);
          if ($urandom_range(1)) add(any_hex(), 1'b0);
          add(non_hex(), 1'b0);
        end
      endcase
    end
    // sometimes the string ends mid-escape
    case ($urandom_range(7))
      6: add(PCT_CHAR, 1'b0);
      7: begin
        add(PCT_CHAR, 1'b0);
        add(any_hex(), 1'b0);
      end
      default: ;
    endcase
    pending_q[pending_q.size() - 1].tl = 1'b1;
    return pending_q.size() - start;
  endfunction

  // strings with some raw noise, closed by a final byte
  function automatic void fill_random(input int target);
    int added;
    added = 0;
    while (added < target) begin
      if ($urandom_range(9) < 8) begin
        added += add_string();
      end else begin
        add(8'($urandom_range(1, 255)), $urandom_range(7) == 0);
        added++;
      end
    end
    if (!pending_q[pending_q.size() - 1].tl) add(8'($urandom_range(1, 255)), 1'b1);
  endfunction

  // wait for every byte to go in and every decoded byte to come out
  task automatic wait_drained(input bit settle);
    while (pending_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_form_mode(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    form_mode = v;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: extremes, escapes in both cases, all the failure shapes
    write_form_mode(1'b0);
    add(8'h01, 1'b1);                                       // lowest nonzero byte
    add(8'hFF, 1'b1);                                       // highest byte
    add(PCT_CHAR, 1'b0); add(8'h34, 1'b0); add(8'h31, 1'b0); // %41
    add(PCT_CHAR, 1'b0); add(8'h66, 1'b0); add(8'h46, 1'b0); // %fF
    add(PCT_CHAR, 1'b0); add(8'h32, 1'b0); add(8'h42, 1'b0); // %2B
    add(PLUS_CHAR, 1'b0);
    add(PCT_CHAR, 1'b0); add(8'h47, 1'b0);                   // %G fails
    add(PCT_CHAR, 1'b0); add(8'h34, 1'b0); add(8'h5A, 1'b0); // %4Z fails
    add(PCT_CHAR, 1'b0); add(PCT_CHAR, 1'b0);                // % then %41
    add(8'h34, 1'b0); add(8'h31, 1'b1);
    add(PCT_CHAR, 1'b1);                                     // lone % at end
    add(PCT_CHAR, 1'b0); add(8'h34, 1'b1);                   // %4 at end
    wait_drained(1'b1);

    // form mode, full rate both sides
    write_form_mode(1'b1);
    fill_random(45);
    wait_drained(1'b1);

    // sender gaps
    write_form_mode(1'b0);
    send_idle_pct = 45;
    fill_random(45);
    wait_drained(1'b1);

    // receiver stalls, with a sender pause until all is out
    write_form_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    fill_random(20);
    wait_drained(1'b0);
    fill_random(20);
    wait_drained(1'b1);

    // both sides idle now and then
    send_idle_pct = 13;
    recv_stall_pct = 13;
    fill_random(45);
    wait_drained(1'b1);

    // receiver held off while the sender keeps offering: input must stall
    write_form_mode(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_req = 1'b1;
    fill_random(40);
    wait_drained(1'b1);

    write_form_mode(1'b1);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    fill_random(30);
    wait_drained(1'b1);

    $display("Decoded %0d strings: %0d bytes in, %0d bytes out, %0d escapes, %0d broken",
             n_strings, n_in, n_out, n_escapes, n_broken);
    $display("Both plus modes used; input stalled on %0d cycles, %0d mismatches",
             stall_cycles, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
